/* hdl/breath_phase_detector_macros.svh */
// Assertion macros used by the breath phase detector checker.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef BREATH_PHASE_DETECTOR_MACROS_SVH
`define BREATH_PHASE_DETECTOR_MACROS_SVH

// Clocked property, ignored while reset is high.
`define BPD_ASSERT_CLKD(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked property, checked during reset as well.
`define BPD_ASSERT_ANY(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* hdl/bpd_pkg.sv */
// Shared types, constants and helpers of the breath phase detector.
// Depends on nothing; used by every module of the block.
package bpd_pkg;

  localparam int WINDOW = 20;
  localparam int IDX_W  = $clog2(WINDOW);

  typedef logic signed [15:0] flow_t;
  typedef logic signed [16:0] slope_t;
  typedef logic [7:0]         run_t;

  typedef enum logic [2:0] {
    STAGE_NONE      = 3'd0,
    STAGE_INS_START = 3'd1,
    STAGE_INS_END   = 3'd2,
    STAGE_EX_START  = 3'd3,
    STAGE_EX_END    = 3'd4
  } stage_t;

  typedef enum logic [1:0] {
    SEQ_IDLE,
    SEQ_SCAN,
    SEQ_DECIDE
  } seq_state_t;

  localparam logic [2:0] REG_SPLIT_LEVEL   = 3'd0;
  localparam logic [2:0] REG_SWING_LIMIT   = 3'd1;
  localparam logic [2:0] REG_RISE_SLOPE    = 3'd2;
  localparam logic [2:0] REG_FALL_SLOPE    = 3'd3;
  localparam logic [2:0] REG_RUN_NEEDED    = 3'd4;
  localparam logic [2:0] REG_HOLD_TIMEOUT  = 3'd5;

  localparam flow_t       RST_SPLIT_LEVEL   = 16'sd0;
  localparam logic [15:0] RST_SWING_LIMIT   = 16'd800;
  localparam slope_t      RST_RISE_SLOPE    = 17'sd50;
  localparam slope_t      RST_FALL_SLOPE    = -17'sd40;
  localparam run_t        RST_RUN_NEEDED    = 8'd5;
  localparam logic [15:0] RST_HOLD_TIMEOUT  = 16'd250;

  localparam run_t RUN_MAX = 8'd255;

  typedef struct packed {
    flow_t       split_level;
    logic [15:0] swing_limit;
    slope_t      rise_slope;
    slope_t      fall_slope;
    run_t        run_needed;
    logic [15:0] hold_timeout;
  } cfg_t;

  typedef struct packed {
    logic load;
    logic rotate;
    logic first;
    logic pair_valid;
  } scan_ctrl_t;

  typedef struct packed {
    flow_t hi;
    flow_t lo;
    run_t  rise_cand;
    run_t  fall_cand;
  } scan_result_t;

  function automatic run_t sat_inc(input run_t c);
    return (c == RUN_MAX) ? RUN_MAX : run_t'(c + 8'd1);
  endfunction

endpackage

/* hdl/breath_phase_detector.sv */
// Breath phase detector: one result per flow sample. An accepted sample
// is shifted into the window, which then rotates one step per cycle
// through the shared compare unit before the result is registered; no new
// sample is accepted until then. The output register lets the next
// sample enter while a result waits. Synchronous reset clears the window,
// run counters, stage, hold timer and loads the register defaults.
module breath_phase_detector (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [15:0] flow_sample
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // [2:0] stage, [3] timed_out, [7:4] zero
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [16:0] cfg_data
);

  bpd_pkg::seq_state_t       state;
  bpd_pkg::seq_state_t       state_next;
  logic [bpd_pkg::IDX_W-1:0] idx;
  logic [bpd_pkg::IDX_W-1:0] idx_next;
  bpd_pkg::scan_ctrl_t       ctrl;
  logic                      update;
  logic                      last_step;

  bpd_pkg::cfg_t             cfg;
  bpd_pkg::flow_t            tap0;
  bpd_pkg::flow_t            tap1;
  bpd_pkg::flow_t            newest;
  bpd_pkg::scan_result_t     res;
  bpd_pkg::run_t             rise_run;
  bpd_pkg::run_t             fall_run;
  bpd_pkg::stage_t           stage_next;
  logic                      timed_out;

  assign cfg_ready = 1'b1;
  assign last_step = idx == bpd_pkg::IDX_W'(bpd_pkg::WINDOW - 1);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.split_level   <= bpd_pkg::RST_SPLIT_LEVEL;
      cfg.swing_limit   <= bpd_pkg::RST_SWING_LIMIT;
      cfg.rise_slope    <= bpd_pkg::RST_RISE_SLOPE;
      cfg.fall_slope    <= bpd_pkg::RST_FALL_SLOPE;
      cfg.run_needed    <= bpd_pkg::RST_RUN_NEEDED;
      cfg.hold_timeout  <= bpd_pkg::RST_HOLD_TIMEOUT;
    end else if (cfg_valid) begin
      case (cfg_index)
        bpd_pkg::REG_SPLIT_LEVEL:   cfg.split_level   <= cfg_data[15:0];
        bpd_pkg::REG_SWING_LIMIT:   cfg.swing_limit   <= cfg_data[15:0];
        bpd_pkg::REG_RISE_SLOPE:    cfg.rise_slope    <= cfg_data;
        bpd_pkg::REG_FALL_SLOPE:    cfg.fall_slope    <= cfg_data;
        bpd_pkg::REG_RUN_NEEDED:    cfg.run_needed    <= cfg_data[7:0];
        bpd_pkg::REG_HOLD_TIMEOUT:  cfg.hold_timeout  <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bpd_pkg::SEQ_IDLE;
      idx   <= '0;
    end else begin
      state <= state_next;
      idx   <= idx_next;
    end
  end

  always_comb begin
    state_next      = state;
    idx_next        = idx;
    ctrl            = '0;
    update          = 1'b0;
    s_tready        = 1'b0;
    case (state)
      bpd_pkg::SEQ_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          ctrl.load  = 1'b1;
          idx_next   = '0;
          state_next = bpd_pkg::SEQ_SCAN;
        end
      end
      bpd_pkg::SEQ_SCAN: begin
        ctrl.rotate     = 1'b1;
        ctrl.first      = idx == '0;
        ctrl.pair_valid = !last_step;
        idx_next        = idx + 1'b1;
        if (last_step) begin
          idx_next   = '0;
          state_next = bpd_pkg::SEQ_DECIDE;
        end
      end
      bpd_pkg::SEQ_DECIDE: begin
        if (!m_tvalid || m_tready) begin
          update     = 1'b1;
          state_next = bpd_pkg::SEQ_IDLE;
        end
      end
      default: state_next = bpd_pkg::SEQ_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (update) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (update) begin
      m_tdata <= {4'b0000, timed_out, 3'(stage_next)};
    end
  end

  bpd_window u_window (
    .clk    (clk),
    .rst    (rst),
    .ctrl   (ctrl),
    .sample (s_tdata),
    .tap0   (tap0),
    .tap1   (tap1),
    .newest (newest)
  );

  bpd_scan_unit u_scan (
    .clk      (clk),
    .ctrl     (ctrl),
    .tap0     (tap0),
    .tap1     (tap1),
    .cfg      (cfg),
    .rise_run (rise_run),
    .fall_run (fall_run),
    .res      (res)
  );

  bpd_phase u_phase (
    .clk        (clk),
    .rst        (rst),
    .update     (update),
    .sample     (newest),
    .cfg        (cfg),
    .res        (res),
    .rise_run   (rise_run),
    .fall_run   (fall_run),
    .stage_next (stage_next),
    .timed_out  (timed_out)
  );

endmodule

/* hdl/bpd_window.sv */
// Sample window of the breath phase detector: shift-in and rotate register.
// Depends on bpd_pkg.
module bpd_window (
  input  logic                clk,
  input  logic                rst,
  input  bpd_pkg::scan_ctrl_t ctrl,
  input  bpd_pkg::flow_t      sample,
  output bpd_pkg::flow_t      tap0,
  output bpd_pkg::flow_t      tap1,
  output bpd_pkg::flow_t      newest
);

  bpd_pkg::flow_t win [bpd_pkg::WINDOW];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < bpd_pkg::WINDOW; i++) begin
        win[i] <= '0;
      end
    end else if (ctrl.load) begin
      for (int i = 0; i < bpd_pkg::WINDOW - 1; i++) begin
        win[i] <= win[i + 1];
      end
      win[bpd_pkg::WINDOW - 1] <= sample;
    end else if (ctrl.rotate) begin
      for (int i = 0; i < bpd_pkg::WINDOW - 1; i++) begin
        win[i] <= win[i + 1];
      end
      win[bpd_pkg::WINDOW - 1] <= win[0];
    end
  end

  assign tap0   = win[0];
  assign tap1   = win[1];
  assign newest = win[bpd_pkg::WINDOW - 1];

endmodule

/* hdl/bpd_scan_unit.sv */
// Shared compare unit: running min/max and rise/fall run candidates per step.
// Depends on bpd_pkg.
module bpd_scan_unit (
  input  logic                  clk,
  input  bpd_pkg::scan_ctrl_t   ctrl,
  input  bpd_pkg::flow_t        tap0,
  input  bpd_pkg::flow_t        tap1,
  input  bpd_pkg::cfg_t         cfg,
  input  bpd_pkg::run_t         rise_run,
  input  bpd_pkg::run_t         fall_run,
  output bpd_pkg::scan_result_t res
);

  bpd_pkg::slope_t diff;

  assign diff = bpd_pkg::slope_t'(tap1) - bpd_pkg::slope_t'(tap0);

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      res.rise_cand <= rise_run;
      res.fall_cand <= fall_run;
    end else if (ctrl.rotate) begin
      if (ctrl.first) begin
        res.hi <= tap0;
        res.lo <= tap0;
      end else begin
        if (tap0 > res.hi) res.hi <= tap0;
        if (tap0 < res.lo) res.lo <= tap0;
      end
      if (ctrl.pair_valid) begin
        res.rise_cand <= (diff > cfg.rise_slope) ? bpd_pkg::sat_inc(res.rise_cand) : '0;
        res.fall_cand <= (diff < cfg.fall_slope) ? bpd_pkg::sat_inc(res.fall_cand) : '0;
      end
    end
  end

endmodule

/* hdl/bpd_phase.sv */
// Phase state of the breath phase detector: run counters, stage and hold timer.
// Depends on bpd_pkg.
module bpd_phase (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  update,
  input  bpd_pkg::flow_t        sample,
  input  bpd_pkg::cfg_t         cfg,
  input  bpd_pkg::scan_result_t res,
  output bpd_pkg::run_t         rise_run,
  output bpd_pkg::run_t         fall_run,
  output bpd_pkg::stage_t       stage_next,
  output logic                  timed_out
);

  bpd_pkg::stage_t cur_stage;
  bpd_pkg::stage_t prev_stage;
  logic [15:0]     hold_ticks;

  bpd_pkg::run_t   rise_run_next;
  bpd_pkg::run_t   fall_run_next;
  bpd_pkg::stage_t prev_stage_next;
  logic [15:0]     hold_ticks_next;
  bpd_pkg::stage_t st;
  bpd_pkg::slope_t swing;
  logic            big;
  logic            above;
  logic            below;

  assign swing = bpd_pkg::slope_t'(res.hi) - bpd_pkg::slope_t'(res.lo);
  assign big   = swing[15:0] > cfg.swing_limit;
  assign above = sample > cfg.split_level;
  assign below = sample < cfg.split_level;

  always_comb begin
    rise_run_next   = rise_run;
    fall_run_next   = fall_run;
    st              = cur_stage;
    prev_stage_next = prev_stage;
    hold_ticks_next = hold_ticks;
    timed_out       = 1'b0;
    if (big) begin
      if (above) begin
        rise_run_next = res.rise_cand;
        fall_run_next = '0;
      end else if (below) begin
        rise_run_next = '0;
        fall_run_next = res.fall_cand;
      end
      if (rise_run_next >= cfg.run_needed &&
          (st == bpd_pkg::STAGE_EX_END || st == bpd_pkg::STAGE_NONE)) begin
        st = bpd_pkg::STAGE_INS_START;
      end
      if (fall_run_next >= cfg.run_needed && st == bpd_pkg::STAGE_INS_END) begin
        st = bpd_pkg::STAGE_EX_START;
      end
    end else begin
      if (st == bpd_pkg::STAGE_INS_START && above) begin
        st = bpd_pkg::STAGE_INS_END;
      end else if (st == bpd_pkg::STAGE_EX_START && below) begin
        st = bpd_pkg::STAGE_EX_END;
      end
    end
    if (st != prev_stage) begin
      hold_ticks_next = '0;
      prev_stage_next = st;
    end else if (hold_ticks >= cfg.hold_timeout) begin
      hold_ticks_next = '0;
      st              = bpd_pkg::STAGE_NONE;
      timed_out       = 1'b1;
    end else begin
      hold_ticks_next = hold_ticks + 16'd1;
    end
    stage_next = st;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rise_run   <= '0;
      fall_run   <= '0;
      cur_stage  <= bpd_pkg::STAGE_NONE;
      prev_stage <= bpd_pkg::STAGE_NONE;
      hold_ticks <= '0;
    end else if (update) begin
      rise_run   <= rise_run_next;
      fall_run   <= fall_run_next;
      cur_stage  <= stage_next;
      prev_stage <= prev_stage_next;
      hold_ticks <= hold_ticks_next;
    end
  end

endmodule

/* hdl/bpd_checker.sv */
// Port-level checks of the breath phase detector, bound to the top level.
// Depends on bpd_pkg and breath_phase_detector_macros.svh.
`include "breath_phase_detector_macros.svh"

module bpd_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [7:0]  m_tdata
);

  `BPD_ASSERT_CLKD(a_out_hold, clk, rst, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "result changed while stalled")
  `BPD_ASSERT_CLKD(a_busy_after_in, clk, rst, s_tvalid && s_tready |=> !s_tready, "accepted a sample while scanning")
  `BPD_ASSERT_CLKD(a_timeout_none, clk, rst, m_tvalid && m_tdata[3] |-> m_tdata[2:0] == bpd_pkg::STAGE_NONE, "timeout without stage none")
  `BPD_ASSERT_ANY(a_reset_empty, clk, rst |=> !m_tvalid, "result valid after reset")

endmodule

bind breath_phase_detector bpd_checker u_bpd_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

/* bench/tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for breath_phase_detector: streams flow samples in,
// predicts stage and timeout per sample and checks each result in order.
// Depends on bpd_pkg and the breath_phase_detector RTL.
module tb;
  import bpd_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASE_ITEMS = 156;
  localparam logic [2:0] REG_SPARE_LO = 3'd6;
  localparam logic [2:0] REG_SPARE_HI = 3'd7;

  typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

  typedef struct packed {
    stage_t stage;
    logic   timed_out;
  } phase_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata = '0;     // [15:0] flow_sample
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;          // [2:0] stage, [3] timed_out, [7:4] zero
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [16:0] cfg_data = '0;

  flow_t       win [WINDOW];
  run_t        rise_cnt, fall_cnt;
  stage_t      cur_stage, prev_stage;
  logic [15:0] hold_cnt;
  flow_t       base_lvl;
  logic [15:0] swing_lim;
  slope_t      rise_thr, fall_thr;
  run_t        run_min;
  logic [15:0] hold_max;

  flow_t         flow_backlog [$];
  phase_result_t predicted_phases [$];
  phase_result_t want;
  stage_t        next_stage;
  logic          next_tmo;
  logic          flow_taken = 1'b0;
  int            idle_pct = 0;
  int            stall_pct = 0;
  int            flow_level = 0;
  int            fail_count = 0;
  int            cycle_count = 0;
  int            samples_in = 0;
  int            settings_used = 0;
  int            timeouts_seen = 0;
  logic [7:0]    stages_seen = '0;

  breath_phase_detector uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always #5 clk = ~clk;

  function automatic void predict_phase(input flow_t sample, output stage_t stg,
                                        output logic tmo);
    int hi, lo;
    tmo = 1'b0;
    for (int i = 0; i < WINDOW - 1; i++) win[i] = win[i + 1];
    win[WINDOW - 1] = sample;
    hi = win[0];
    lo = win[0];
    for (int i = 1; i < WINDOW; i++) begin
      if (win[i] > hi) hi = win[i];
      if (win[i] < lo) lo = win[i];
    end
    if (hi - lo > int'(swing_lim)) begin
      if (sample > base_lvl) begin
        for (int i = 0; i < WINDOW - 1; i++) begin
          if (int'(win[i + 1]) - int'(win[i]) > int'(rise_thr)) begin
            rise_cnt = (rise_cnt == RUN_MAX) ? RUN_MAX : rise_cnt + 8'd1;
            fall_cnt = '0;
          end else begin
            rise_cnt = '0;
            fall_cnt = '0;
          end
        end
      end else if (sample < base_lvl) begin
        for (int i = 0; i < WINDOW - 1; i++) begin
          if (int'(win[i + 1]) - int'(win[i]) < int'(fall_thr)) begin
            fall_cnt = (fall_cnt == RUN_MAX) ? RUN_MAX : fall_cnt + 8'd1;
            rise_cnt = '0;
          end else begin
            rise_cnt = '0;
            fall_cnt = '0;
          end
        end
      end
      if (rise_cnt >= run_min && (cur_stage == STAGE_EX_END || cur_stage == STAGE_NONE))
        cur_stage = STAGE_INS_START;
      if (fall_cnt >= run_min && cur_stage == STAGE_INS_END)
        cur_stage = STAGE_EX_START;
    end else if (cur_stage == STAGE_INS_START && sample > base_lvl) begin
      cur_stage = STAGE_INS_END;
    end else if (cur_stage == STAGE_EX_START && sample < base_lvl) begin
      cur_stage = STAGE_EX_END;
    end
    if (cur_stage != prev_stage) begin
      hold_cnt = '0;
      prev_stage = cur_stage;
    end else if (hold_cnt >= hold_max) begin
      hold_cnt = '0;
      cur_stage = STAGE_NONE;
      tmo = 1'b1;
    end else begin
      hold_cnt = hold_cnt + 16'd1;
    end
    stg = cur_stage;
  endfunction

  function automatic int pick_in(input int lo, input int hi);
    return int'($urandom_range(hi, lo));
  endfunction

  function automatic void queue_flow(input int v);
    if (v > 32767) v = 32767;
    else if (v < -32768) v = -32768;
    flow_level = v;
    flow_backlog.push_back(flow_t'(v));
  endfunction

  // Mostly full breaths shaped by the current slopes; the rest noise and cut-off ramps.
  function automatic int queue_segment();
    int up, dn, len, pick, n, center;
    n = 0;
    pick = pick_in(0, 99);
    up = (rise_thr < 0) ? 1 : int'(rise_thr) + 1;
    if (up > 2000) up = pick_in(1, 300);
    dn = (fall_thr > 0) ? 1 : 1 - int'(fall_thr);
    if (dn > 2000) dn = pick_in(1, 300);
    if (pick < 75) begin
      flow_level = int'(base_lvl) - pick_in(0, 1500);
      len = pick_in(3, 40);
      repeat (len) queue_flow(flow_level + up + pick_in(0, 60));
      n += len;
      center = flow_level;
      len = pick_in(0, 30);
      repeat (len) queue_flow(center + pick_in(0, 20) - 10);
      n += len;
      len = pick_in(3, 40);
      repeat (len) queue_flow(flow_level - dn - pick_in(0, 60));
      n += len;
      center = flow_level;
      len = pick_in(0, 30);
      repeat (len) queue_flow(center + pick_in(0, 20) - 10);
      n += len;
    end else if (pick < 88) begin
      len = pick_in(1, 10);
      repeat (len) begin
        if (pick_in(0, 3) == 0) queue_flow(int'(base_lvl));
        else queue_flow(pick_in(0, 65535) - 32768);
      end
      n += len;
    end else begin
      len = pick_in(1, 4);
      repeat (len) queue_flow(flow_level + up + pick_in(0, 200));
      n += len;
      len = pick_in(1, 4);
      repeat (len) queue_flow(flow_level - dn - pick_in(0, 200));
      n += len;
      len = pick_in(1, 3);
      repeat (len) queue_flow(int'(base_lvl));
      n += len;
    end
    return n;
  endfunction

  // Call at a falling edge; leaves cfg_valid high for a following write.
  task automatic write_reg(input logic [2:0] idx, input logic [16:0] val);
    cfg_index <= idx;
    cfg_data  <= val;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_SPLIT_LEVEL:   base_lvl  = val[15:0];
      REG_SWING_LIMIT:   swing_lim = val[15:0];
      REG_RISE_SLOPE:    rise_thr  = val;
      REG_FALL_SLOPE:    fall_thr  = val;
      REG_RUN_NEEDED:    run_min   = val[7:0];
      REG_HOLD_TIMEOUT:  hold_max  = val[15:0];
      default: begin
      end
    endcase
    @(negedge clk);
  endtask

  task automatic wait_drained();
    while (flow_backlog.size() != 0 || s_tvalid || predicted_phases.size() != 0)
      @(negedge clk);
  endtask

  task automatic run_phase(input int bl, input int sl, input int rs, input int fs,
                           input int rn, input int ht, input idle_mode_t mode);
    int queued;
    queued = 0;
    wait_drained();
    repeat (WINDOW + 4) @(negedge clk);
    write_reg(REG_SPLIT_LEVEL, 17'(bl));
    write_reg(REG_SWING_LIMIT, 17'(sl));
    write_reg(REG_RISE_SLOPE, 17'(rs));
    write_reg(REG_FALL_SLOPE, 17'(fs));
    write_reg(REG_RUN_NEEDED, 17'(rn));
    write_reg(REG_HOLD_TIMEOUT, 17'(ht));
    write_reg(REG_SPARE_LO, 17'($urandom));
    write_reg(REG_SPARE_HI, 17'($urandom));
    cfg_valid <= 1'b0;
    settings_used++;
    case (mode)
      IDLE_NONE: begin
        idle_pct = 0;
        stall_pct = 0;
      end
      IDLE_SEND: begin
        idle_pct = 74;
        stall_pct = 0;
      end
      IDLE_RECV: begin
        idle_pct = 0;
        stall_pct = 74;
      end
      default: begin
        idle_pct = 37;
        stall_pct = 37;
      end
    endcase
    while (queued < PHASE_ITEMS) queued += queue_segment();
    // Trim the last segment so every setting sends the same number of samples.
    while (flow_backlog.size() > PHASE_ITEMS) void'(flow_backlog.pop_back());
  endtask

  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || flow_taken) begin
      if (flow_backlog.size() != 0 && pick_in(0, 99) >= idle_pct) begin
        s_tdata  <= flow_backlog.pop_front();
        s_tvalid <= 1'b1;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    m_tready <= (pick_in(0, 99) >= stall_pct);
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles, %0d results outstanding",
               cycle_count, predicted_phases.size());
      $display("RESULT: ERROR");
      $finish;
    end else if (!rst) begin
      if (m_tvalid && m_tready) begin
        if (predicted_phases.size() == 0) begin
          $error("result with no sample pending: stage %0d, timed_out %0b",
                 m_tdata[2:0], m_tdata[3]);
          fail_count++;
        end else begin
          want = predicted_phases.pop_front();
          if (m_tdata[2:0] !== want.stage) begin
            $error("stage: expected %0d, got %0d", want.stage, m_tdata[2:0]);
            fail_count++;
          end
          if (m_tdata[3] !== want.timed_out) begin
            $error("timed_out: expected %0b, got %0b", want.timed_out, m_tdata[3]);
            fail_count++;
          end
          stages_seen[want.stage] = 1'b1;
          if (want.timed_out) timeouts_seen++;
        end
      end
      flow_taken = s_tvalid && s_tready;
      if (flow_taken) begin
        predict_phase(flow_t'(s_tdata), next_stage, next_tmo);
        predicted_phases.push_back('{next_stage, next_tmo});
        samples_in++;
      end
    end
  end

  initial begin
    foreach (win[i]) win[i] = '0;
    rise_cnt   = '0;
    fall_cnt   = '0;
    cur_stage  = STAGE_NONE;
    prev_stage = STAGE_NONE;
    hold_cnt   = '0;
    base_lvl   = RST_SPLIT_LEVEL;
    swing_lim  = RST_SWING_LIMIT;
    rise_thr   = RST_RISE_SLOPE;
    fall_thr   = RST_FALL_SLOPE;
    run_min    = RST_RUN_NEEDED;
    hold_max   = RST_HOLD_TIMEOUT;
    repeat (6) @(negedge clk);
    rst <= 1'b0;

    queue_flow(-32768);
    queue_flow(32767);
    queue_flow(0);
    queue_flow(-1);
    for (int k = 0; k < 8; k++) queue_flow(k * 1000);
    for (int k = 7; k >= 0; k--) queue_flow(k * 1000 - 1000);
    queue_flow(0);
    queue_flow(0);

    run_phase(0, 800, 50, -40, 5, 40, IDLE_SEND);
    run_phase(-32768, 0, -65536, 65535, 0, 0, IDLE_RECV);
    run_phase(32767, 65535, 65535, -65536, 255, 65535, IDLE_BOTH);
    run_phase(1000, 300, 10, -10, 3, 20, IDLE_NONE);
    run_phase(-500, 2000, 100, -100, 8, 60, IDLE_SEND);
    run_phase(0, 100, 0, 0, 1, 1, IDLE_RECV);
    run_phase(200, 800, 50, -40, 20, 120, IDLE_BOTH);
    run_phase(0, 800, 50, -40, 5, 250, IDLE_NONE);

    wait_drained();
    repeat (2 * WINDOW + 10) @(negedge clk);
    if (predicted_phases.size() != 0) begin
      $error("%0d expected results never arrived", predicted_phases.size());
      fail_count++;
    end
    $display("Checked %0d flow samples under reset defaults and %0d register settings.",
             samples_in, settings_used);
    $display("Stage codes observed (one bit per code): %b; forced timeouts: %0d.",
             stages_seen[4:0], timeouts_seen);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
